// ===== src/spr_pkg.sv =====
// Shared constants, control word layout and microprogram of the ramp profiler.
`timescale 1ns / 1ps
package spr_pkg;

  // Default build constants
  localparam int unsigned RAMP_MS_DEFAULT          = 500;
  localparam int unsigned TICKS_PER_SECOND_DEFAULT = 1000;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FREQUENCY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIME_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_VELOCITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE_TENTHS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY              = 3'd5;

  // Field widths
  localparam int unsigned FREQ_W  = 20;
  localparam int unsigned TIME_W  = 22;
  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned DUTY_W  = 20;
  localparam int unsigned REV_W   = 32;
  localparam int unsigned RAMP_W  = 17;   // Q1.16, 65536 = 1.0

  localparam int unsigned RATE_W = FREQ_W + ANGLE_W;    // angle * frequency
  localparam int unsigned PROD_W = RATE_W + TIME_W;     // angle * frequency * time

  localparam logic [FREQ_W-1:0]  TARGET_RESET = '0;
  localparam logic [TIME_W-1:0]  RUN_RESET    = '0;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 12'd18;
  localparam logic [DUTY_W-1:0]  DUTY_RESET   = 20'd500000;

  // Sequencer
  localparam int unsigned UPC_W = 3;
  localparam logic [UPC_W-1:0] UPC_FETCH   = 3'd0;
  localparam logic [UPC_W-1:0] UPC_DECIDE  = 3'd1;
  localparam logic [UPC_W-1:0] UPC_SCALE   = 3'd2;
  localparam logic [UPC_W-1:0] UPC_RECIP   = 3'd3;
  localparam logic [UPC_W-1:0] UPC_REMAIN  = 3'd4;
  localparam logic [UPC_W-1:0] UPC_FIX     = 3'd5;
  localparam logic [UPC_W-1:0] UPC_EMIT    = 3'd6;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_IN,
    JMP_OUT_BUSY
  } jump_cond_t;

  typedef struct packed {
    logic             ld_in;     // take a tick word
    logic             decide;    // resolve run state, read ramp table, first multiply
    logic             mul_scale; // scale target by ramp entry, second multiply
    logic             recip;     // saturation check, reciprocal quotient estimate
    logic             remain;    // remainder of the estimate
    logic             fix;       // correct the estimate from the remainder
    logic             emit;      // load output register
    logic             ret;       // fall through to fetch
    jump_cond_t       cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{ld_in: 1'b0, decide: 1'b0, mul_scale: 1'b0, recip: 1'b0, remain: 1'b0,
           fix: 1'b0, emit: 1'b0, ret: 1'b0, cond: JMP_NONE, target: UPC_FETCH};
    unique case (pc)
      UPC_FETCH: begin
        cw.ld_in  = 1'b1;
        cw.cond   = JMP_NO_IN;
        cw.target = UPC_FETCH;
      end
      UPC_DECIDE:  cw.decide    = 1'b1;
      UPC_SCALE:   cw.mul_scale = 1'b1;
      UPC_RECIP:   cw.recip     = 1'b1;
      UPC_REMAIN:  cw.remain    = 1'b1;
      UPC_FIX:     cw.fix       = 1'b1;
      UPC_EMIT: begin
        cw.emit   = 1'b1;
        cw.ret    = 1'b1;
        cw.cond   = JMP_OUT_BUSY;
        cw.target = UPC_EMIT;
      end
      default: cw.ret = 1'b1;
    endcase
    return cw;
  endfunction

endpackage

// ===== src/stepper_pump_ramp_profiler_top.sv =====
// Ramp profiler top level: microcoded sequencer, ramp table, divider and output register.
//
//   channel  dir  handshake              fields
//   in       in   in_valid / in_ready    start_req, preempt
//   out      out  out_valid / out_ready  motor_enable .. succeeded
//   cfg      in   cfg_write              cfg_index, cfg_data
//
// A tick runs through fetch, decide, multiply/scale, reciprocal estimate, remainder,
// quotient correction and the output load. Division by 60*TICKS_PER_SECOND is a reciprocal
// multiply that lands at most three below the quotient, fixed by remainder compare and add.
// Reset is synchronous and clears the sequencer, run state and config registers to defaults;
// the ramp table is constant and needs no fill. A result waits in the output register
// while the next tick is taken; the sequencer holds at its last step until it is free.
`timescale 1ns / 1ps
module stepper_pump_ramp_profiler_top #(
  parameter int unsigned RAMP_MS          = spr_pkg::RAMP_MS_DEFAULT,
  parameter int unsigned TICKS_PER_SECOND = spr_pkg::TICKS_PER_SECOND_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_req,
  input  logic                          preempt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          motor_enable,
  output logic                          direction_out,
  output logic [spr_pkg::FREQ_W-1:0]    step_frequency,
  output logic [spr_pkg::DUTY_W-1:0]    duty_out,
  output logic [spr_pkg::TIME_W-1:0]    elapsed_ms,
  output logic [spr_pkg::REV_W-1:0]     revolutions,
  output logic                          running,
  output logic                          finished,
  output logic                          succeeded
);
  import spr_pkg::*;

  localparam int unsigned IDX_W     = $clog2(RAMP_MS + 1);
  localparam int unsigned DivConst  = 60 * TICKS_PER_SECOND;
  localparam int unsigned DIV_W     = $clog2(DivConst);
  localparam int unsigned REM_W     = DIV_W + 2;
  localparam logic [63:0] Q30_ONE   = 64'd1073741824;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] Q16_ONE   = 64'd65536;

  // floor(2^(32+DIV_W) / divisor), below 2^33
  localparam logic [REV_W:0]   RECIP  = (REV_W+1)'((64'd1 << (REV_W + DIV_W)) /
                                                   64'(DivConst));
  localparam logic [REM_W-1:0] DIV_K1 = REM_W'(DivConst);
  localparam logic [REM_W-1:0] DIV_K2 = REM_W'(2 * DivConst);
  localparam logic [REM_W-1:0] DIV_K3 = REM_W'(3 * DivConst);

  // Raised-cosine table, evaluated at elaboration
  function automatic logic [63:0] cos_q30(input logic [63:0] k);
    logic [63:0] theta, t, a, s;
    theta = (PI_Q30 * k) / 64'(RAMP_MS);
    t = (theta * theta) >> 30;
    a = Q30_ONE;
    s = ((t * a) >> 30) / 64'd90;
    a = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s = ((t * a) >> 30) / 64'd56;
    a = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s = ((t * a) >> 30) / 64'd30;
    a = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s = ((t * a) >> 30) / 64'd12;
    a = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s = ((t * a) >> 30) / 64'd2;
    a = (s > Q30_ONE) ? 64'd0 : Q30_ONE - s;
    return a;
  endfunction

  function automatic logic [RAMP_W-1:0] ramp_entry(input logic [63:0] k);
    logic [63:0] e;
    if (2 * k <= 64'(RAMP_MS)) begin
      e = (Q30_ONE - cos_q30(k) + 64'd16384) >> 15;
    end else begin
      e = Q16_ONE - ((Q30_ONE - cos_q30(64'(RAMP_MS) - k) + 64'd16384) >> 15);
    end
    return RAMP_W'(e);
  endfunction

  logic [RAMP_W-1:0] rom_tbl [RAMP_MS+1];

  for (genvar g = 0; g <= RAMP_MS; g++) begin : g_rom
    assign rom_tbl[g] = ramp_entry(64'(g));
  end

  // Configuration registers
  logic                 direction;
  logic [FREQ_W-1:0]    target_frequency;
  logic [TIME_W-1:0]    run_time_ms;
  logic                 constant_velocity;
  logic [ANGLE_W-1:0]   step_angle_tenths;
  logic [DUTY_W-1:0]    duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction         <= 1'b0;
      target_frequency  <= TARGET_RESET;
      run_time_ms       <= RUN_RESET;
      constant_velocity <= 1'b1;
      step_angle_tenths <= ANGLE_RESET;
      duty              <= DUTY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIRECTION:         direction         <= cfg_data[0];
        CFG_TARGET_FREQUENCY:  target_frequency  <= cfg_data[FREQ_W-1:0];
        CFG_RUN_TIME_MS:       run_time_ms       <= cfg_data[TIME_W-1:0];
        CFG_CONSTANT_VELOCITY: constant_velocity <= cfg_data[0];
        CFG_STEP_ANGLE_TENTHS: step_angle_tenths <= cfg_data[ANGLE_W-1:0];
        CFG_DUTY:              duty              <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  logic [UPC_W-1:0] pc, pc_next;
  ctrl_word_t       cw;
  logic             jump;
  logic             accept, emit_fire;

  always_comb begin
    cw = ucode(pc);
  end

  always_comb begin
    unique case (cw.cond)
      JMP_NONE:     jump = 1'b0;
      JMP_ALWAYS:   jump = 1'b1;
      JMP_NO_IN:    jump = !in_valid;
      JMP_OUT_BUSY: jump = out_valid && !out_ready;
      default:      jump = 1'b0;
    endcase
    if (jump) begin
      pc_next = cw.target;
    end else if (cw.ret) begin
      pc_next = UPC_FETCH;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  assign in_ready  = cw.ld_in;
  assign accept    = cw.ld_in && in_valid;
  assign emit_fire = cw.emit && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UPC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Run state and per-tick datapath
  logic                 active;
  logic [TIME_W-1:0]    elapsed_count;
  logic [FREQ_W-1:0]    held_frequency;
  logic [TIME_W-1:0]    t_q;
  logic                 act_q, pre_q;
  logic                 run_q, fin_q, ok_q, scale_q;
  logic [RAMP_W-1:0]    rom_q;
  logic [RATE_W-1:0]    p1;
  logic [PROD_W-1:0]    p2;
  logic                 sat_q;
  logic [REV_W-1:0]     q_est;
  logic [REM_W-1:0]     rem;
  logic [REV_W-1:0]     dq;

  logic                 at_end, near_end, in_rise, scale_now;
  logic [IDX_W-1:0]     rom_idx;
  logic [FREQ_W+RAMP_W-1:0] scaled;
  logic [REV_W-1:0]     n_hi;
  logic [2*REV_W:0]     q_prod;
  logic [REM_W-1:0]     q_back;
  logic [1:0]           q_fix;

  always_comb begin
    at_end    = (t_q >= run_time_ms);
    in_rise   = ((TIME_W+1)'(t_q) < (TIME_W+1)'(RAMP_MS));
    near_end  = ((TIME_W+1)'(t_q) + (TIME_W+1)'(RAMP_MS)) > (TIME_W+1)'(run_time_ms);
    scale_now = act_q && !pre_q && !at_end && !constant_velocity && (in_rise || near_end);
    if (!scale_now) begin
      rom_idx = '0;
    end else if (in_rise) begin
      rom_idx = IDX_W'(t_q);
    end else begin
      rom_idx = IDX_W'(run_time_ms - t_q);
    end
    scaled = FREQ_W'(target_frequency) * rom_q;
    // high part fits 32 bits unless the quotient saturates
    n_hi   = REV_W'(p2 >> DIV_W);
    q_prod = n_hi * RECIP;
    // only the low bits matter, the remainder stays below four divisors
    q_back = REM_W'(q_est) * DIV_K1;
    priority if (rem >= DIV_K3) begin
      q_fix = 2'd3;
    end else if (rem >= DIV_K2) begin
      q_fix = 2'd2;
    end else if (rem >= DIV_K1) begin
      q_fix = 2'd1;
    end else begin
      q_fix = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      elapsed_count  <= '0;
      held_frequency <= '0;
      act_q          <= 1'b0;
      pre_q          <= 1'b0;
      run_q          <= 1'b0;
      fin_q          <= 1'b0;
      ok_q           <= 1'b0;
      scale_q        <= 1'b0;
      sat_q          <= 1'b0;
    end else begin
      if (accept) begin
        // a start request restarts the run at zero
        t_q   <= start_req ? '0 : elapsed_count;
        act_q <= start_req || active;
        pre_q <= preempt;
        if (start_req) begin
          active         <= 1'b1;
          elapsed_count  <= '0;
          held_frequency <= '0;
        end
      end
      if (cw.decide) begin
        fin_q   <= act_q && (pre_q || at_end);
        ok_q    <= act_q && !pre_q && at_end;
        run_q   <= act_q && !pre_q && !at_end;
        scale_q <= scale_now;
        if (act_q && (pre_q || at_end)) begin
          active <= 1'b0;
        end
        if (act_q && !pre_q && !at_end) begin
          elapsed_count <= t_q + 1'b1;
          if (constant_velocity) begin
            held_frequency <= target_frequency;
          end
        end
      end
      if (cw.mul_scale && scale_q) begin
        held_frequency <= scaled[RAMP_W-1 +: FREQ_W];
      end
      if (cw.recip) begin
        sat_q <= (32'(p2[PROD_W-1:REV_W]) >= 32'(DivConst));
      end
    end
  end

  // Payload registers of the datapath
  always_ff @(posedge clk) begin
    if (cw.decide) begin
      rom_q <= rom_tbl[rom_idx];
      p1    <= step_angle_tenths * target_frequency;
    end
    if (cw.mul_scale) begin
      p2 <= p1 * t_q;
    end
    if (cw.recip) begin
      q_est <= q_prod[REV_W +: REV_W];
    end
    if (cw.remain) begin
      rem <= REM_W'(p2) - q_back;
    end
    if (cw.fix) begin
      dq <= q_est + REV_W'(q_fix);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      motor_enable   <= run_q;
      direction_out  <= run_q && direction;
      step_frequency <= run_q ? held_frequency : '0;
      duty_out       <= run_q ? duty : '0;
      elapsed_ms     <= t_q;
      revolutions    <= sat_q ? '1 : dq;
      running        <= run_q;
      finished       <= fin_q;
      succeeded      <= ok_q;
    end
  end

  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !running && !motor_enable && step_frequency == '0)
    else $error("ending word still drives the motor");

  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && succeeded |-> finished)
    else $error("success reported without run end");

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer took a word while busy");

endmodule

// ===== bench/tb_stepper_pump_ramp_profiler_top.sv =====
// Self-checking bench for the ramp profiler: directed tick table, then random runs against a tick predictor.
`timescale 1ns / 1ps
module tb_stepper_pump_ramp_profiler_top;
  import spr_pkg::*;

  localparam int unsigned     RAMP_LEN         = RAMP_MS_DEFAULT;
  localparam longint unsigned TICKS_PER_MINUTE = 60 * TICKS_PER_SECOND_DEFAULT;
  localparam longint unsigned Q30_ONE          = 64'd1 << 30;
  localparam longint unsigned PI_Q30           = 64'd3373259426;
  localparam longint unsigned REV_MAX          = 64'hFFFF_FFFF;
  localparam longint unsigned HORNER_DIV [5]   = '{90, 56, 30, 12, 2};

  localparam int IDLE_PCT      = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 80;
  localparam int LONG_RUN_MS   = 1002;
  localparam int LONG_TICKS    = LONG_RUN_MS + 3;
  localparam int SHORT_PHASES  = 6;
  localparam int SHORT_TICKS   = 25;
  localparam int DIRECTED_ROWS = 23;

  typedef struct packed {
    logic              motor_enable;
    logic              direction_out;
    logic [FREQ_W-1:0] step_frequency;
    logic [DUTY_W-1:0] duty_out;
    logic [TIME_W-1:0] elapsed_ms;
    logic [REV_W-1:0]  revolutions;
    logic              running;
    logic              finished;
    logic              succeeded;
  } motor_word_t;

  // raw register values, masked by the block on write
  typedef struct packed {
    logic [CFG_DATA_W-1:0] dir;
    logic [CFG_DATA_W-1:0] target;
    logic [CFG_DATA_W-1:0] run_len;
    logic [CFG_DATA_W-1:0] const_mode;
    logic [CFG_DATA_W-1:0] angle;
    logic [CFG_DATA_W-1:0] duty;
  } setting_t;

  typedef struct packed {
    logic        apply;
    logic        go;
    logic        stop;
    logic        pinned;
    motor_word_t want;
  } tick_row_t;

  localparam motor_word_t QUIET        = '0;
  localparam motor_word_t DONE_AT_ZERO = '{finished: 1'b1, succeeded: 1'b1, default: '0};
  localparam motor_word_t CUT_AT_ZERO  = '{finished: 1'b1, default: '0};
  localparam motor_word_t FULL_START   = '{motor_enable: 1'b1, direction_out: 1'b1,
                                           step_frequency: 20'hFFFFF, duty_out: 20'd1000000,
                                           running: 1'b1, default: '0};
  localparam motor_word_t DONE_AT_3    = '{elapsed_ms: 22'd3, revolutions: 32'd214695,
                                           finished: 1'b1, succeeded: 1'b1, default: '0};
  localparam motor_word_t RAMP_START   = '{motor_enable: 1'b1, running: 1'b1, default: '0};

  localparam setting_t DIRECTED_SETTINGS [2] = '{
    '{22'd1, 22'h3FFFFF, 22'd3, 22'd1, 22'h3FFFFF, 22'd1000000},
    '{22'd0, 22'd1000000, 22'd6, 22'd0, 22'd1, 22'd0}
  };

  // apply, start, preempt, pinned, pinned word
  localparam tick_row_t DIRECTED_TICKS [DIRECTED_ROWS] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1, QUIET},          // reset state
    '{1'b0, 1'b0, 1'b1, 1'b1, QUIET},          // preempt while idle
    '{1'b0, 1'b1, 1'b0, 1'b1, DONE_AT_ZERO},   // zero run time
    '{1'b0, 1'b1, 1'b1, 1'b1, CUT_AT_ZERO},    // start and preempt together
    '{1'b0, 1'b0, 1'b0, 1'b1, QUIET},
    '{1'b1, 1'b1, 1'b0, 1'b1, FULL_START},     // masked maximum target and angle
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b1, DONE_AT_3},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},          // idle shows the last run
    '{1'b0, 1'b1, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b1, 1'b0, 1'b0, QUIET},          // restart while running
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b1, 1'b0, QUIET},          // preempt a run
    '{1'b0, 1'b0, 1'b1, 1'b0, QUIET},
    '{1'b1, 1'b1, 1'b0, 1'b1, RAMP_START},     // short ramp run, rise wins
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET},
    '{1'b0, 1'b0, 1'b0, 1'b0, QUIET}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  start_req = 1'b0;
  logic                  preempt   = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  motor_enable;
  logic                  direction_out;
  logic [FREQ_W-1:0]     step_frequency;
  logic [DUTY_W-1:0]     duty_out;
  logic [TIME_W-1:0]     elapsed_ms;
  logic [REV_W-1:0]      revolutions;
  logic                  running;
  logic                  finished;
  logic                  succeeded;

  stepper_pump_ramp_profiler_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_req      (start_req),
    .preempt        (preempt),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_enable   (motor_enable),
    .direction_out  (direction_out),
    .step_frequency (step_frequency),
    .duty_out       (duty_out),
    .elapsed_ms     (elapsed_ms),
    .revolutions    (revolutions),
    .running        (running),
    .finished       (finished),
    .succeeded      (succeeded)
  );

  // register shadow and run state of the predictor
  logic               sh_dir    = 1'b0;
  logic [FREQ_W-1:0]  sh_target = TARGET_RESET;
  logic [TIME_W-1:0]  sh_run    = RUN_RESET;
  logic               sh_const  = 1'b1;
  logic [ANGLE_W-1:0] sh_angle  = ANGLE_RESET;
  logic [DUTY_W-1:0]  sh_duty   = DUTY_RESET;
  logic               prof_active  = 1'b0;
  logic [TIME_W-1:0]  prof_elapsed = '0;
  logic [FREQ_W-1:0]  prof_held    = '0;
  logic [RAMP_W-1:0]  ramp_q16 [0:RAMP_LEN];

  motor_word_t expected_words [$];
  bit hold_off = 1'b0;
  bit calm     = 1'b0;
  int fail_count      = 0;
  int words_seen      = 0;
  int ticks_sent      = 0;
  int settings_loaded = 0;
  int runs_done       = 0;
  int runs_cut        = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [FREQ_W-1:0] ramp_freq(longint unsigned k);
    longint unsigned prod;
    if (k > RAMP_LEN) k = RAMP_LEN;
    prod = sh_target;
    prod = (prod * ramp_q16[k]) >> 16;
    return prod[FREQ_W-1:0];
  endfunction

  function automatic motor_word_t advance_profile(logic go, logic stop);
    motor_word_t w;
    longint unsigned t;
    longint unsigned r;
    w = '0;
    if (go) begin
      prof_active  = 1'b1;
      prof_elapsed = '0;
      prof_held    = '0;
    end
    t = prof_elapsed;
    if (prof_active) begin
      if (stop) begin
        prof_active = 1'b0;
        w.finished  = 1'b1;
      end else if (t >= sh_run) begin
        prof_active = 1'b0;
        w.finished  = 1'b1;
        w.succeeded = 1'b1;
      end else begin
        // hold the last ramp value between the rise and the fall
        if (sh_const) prof_held = sh_target;
        else if (t < RAMP_LEN) prof_held = ramp_freq(t);
        else if (t + RAMP_LEN > sh_run) prof_held = ramp_freq(sh_run - t);
        w.motor_enable   = 1'b1;
        w.direction_out  = sh_dir;
        w.step_frequency = prof_held;
        w.duty_out       = sh_duty;
        w.running        = 1'b1;
        prof_elapsed     = prof_elapsed + 1'b1;
      end
    end
    r = sh_angle;
    r = r * sh_target * t / TICKS_PER_MINUTE;
    w.elapsed_ms  = t[TIME_W-1:0];
    w.revolutions = (r > REV_MAX) ? REV_MAX[REV_W-1:0] : r[REV_W-1:0];
    return w;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("word %0d: %s expected %0d got %0d", words_seen, name, want, got);
    end
  endtask

  task automatic offer_tick(logic go, logic stop, logic pinned, motor_word_t want);
    motor_word_t w;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    start_req = go;
    preempt   = stop;
    do @(posedge clk); while (!in_ready);
    w = advance_profile(go, stop);
    if (pinned) w = want;
    expected_words.push_back(w);
    ticks_sent++;
    if (w.finished) runs_done++;
    if (w.finished && !w.succeeded) runs_cut++;
  endtask

  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_DIRECTION:         sh_dir    = data[0];
      CFG_TARGET_FREQUENCY:  sh_target = data[FREQ_W-1:0];
      CFG_RUN_TIME_MS:       sh_run    = data[TIME_W-1:0];
      CFG_CONSTANT_VELOCITY: sh_const  = data[0];
      CFG_STEP_ANGLE_TENTHS: sh_angle  = data[ANGLE_W-1:0];
      CFG_DUTY:              sh_duty   = data[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic program_profile(setting_t s);
    write_reg(CFG_DIRECTION, s.dir);
    write_reg(CFG_TARGET_FREQUENCY, s.target);
    write_reg(CFG_RUN_TIME_MS, s.run_len);
    write_reg(CFG_CONSTANT_VELOCITY, s.const_mode);
    write_reg(CFG_STEP_ANGLE_TENTHS, s.angle);
    write_reg(CFG_DUTY, s.duty);
    settings_loaded++;
  endtask

  // receiver: sample at the rising edge, change ready at the falling edge
  initial begin : result_side
    motor_word_t due;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("word %0d arrived with nothing expected", words_seen);
        end else begin
          due = expected_words.pop_front();
          check_field("motor_enable", due.motor_enable, motor_enable);
          check_field("direction_out", due.direction_out, direction_out);
          check_field("step_frequency", due.step_frequency, step_frequency);
          check_field("duty_out", due.duty_out, duty_out);
          check_field("elapsed_ms", due.elapsed_ms, elapsed_ms);
          check_field("revolutions", due.revolutions, revolutions);
          check_field("running", due.running, running);
          check_field("finished", due.finished, finished);
          check_field("succeeded", due.succeeded, succeeded);
        end
      end
      @(negedge clk);
      out_ready = !hold_off && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin : back_pressure
    wait (hold_off);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    #6_000_000;
    $display("timeout with %0d result words outstanding", expected_words.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    longint unsigned theta, sq, acc, step;
    setting_t s;
    int pick;
    int n_set;

    // raised-cosine table, lower half from the series, upper half mirrored
    for (int k = 0; k <= RAMP_LEN; k++) begin
      if (2 * k <= RAMP_LEN) begin
        theta = (PI_Q30 * k) / RAMP_LEN;
        sq    = (theta * theta) >> 30;
        acc   = Q30_ONE;
        for (int j = 0; j < 5; j++) begin
          step = ((sq * acc) >> 30) / HORNER_DIV[j];
          acc  = (step > Q30_ONE) ? 64'd0 : Q30_ONE - step;
        end
        ramp_q16[k] = RAMP_W'((Q30_ONE - acc + 64'd16384) >> 15);
      end else begin
        ramp_q16[k] = 17'd65536 - ramp_q16[RAMP_LEN - k];
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    n_set = 0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED_TICKS[i].apply) begin
        wait_for_quiet();
        program_profile(DIRECTED_SETTINGS[n_set]);
        n_set++;
      end
      offer_tick(DIRECTED_TICKS[i].go, DIRECTED_TICKS[i].stop, DIRECTED_TICKS[i].pinned,
                 DIRECTED_TICKS[i].want);
    end

    // one full ramp run: rise, short hold, whole fall, success
    wait_for_quiet();
    s.dir        = 22'($urandom_range(0, 1));
    s.target     = 22'($urandom_range(500000, 1048575));
    s.run_len    = 22'(LONG_RUN_MS);
    s.const_mode = 22'd0;
    s.angle      = 22'($urandom_range(1, 3600));
    s.duty       = 22'($urandom_range(0, 1000000));
    program_profile(s);
    for (int k = 0; k < LONG_TICKS; k++) begin
      if (k == 300) hold_off = 1'b1;
      calm = (k >= 600 && k < 850);
      offer_tick(k == 0, 1'b0, 1'b0, QUIET);
    end
    calm = 1'b0;

    // short phases: random settings with extremes, random starts and preempts
    for (int p = 0; p < SHORT_PHASES; p++) begin
      wait_for_quiet();
      s.dir = 22'($urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      s.target = (pick == 0) ? 22'd0 : (pick == 1) ? 22'h3FFFFF :
                 (pick == 2) ? 22'd1000000 : 22'($urandom_range(0, 1048575));
      pick = $urandom_range(0, 3);
      s.run_len = (pick == 0) ? 22'd0 : (pick == 1) ? 22'h3FFFFF :
                  22'($urandom_range(1, 20));
      s.const_mode = 22'($urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      s.angle = (pick == 0) ? 22'd1 : (pick == 1) ? 22'd3600 :
                (pick == 2) ? 22'h3FFFFF : 22'($urandom_range(1, 3600));
      pick = $urandom_range(0, 3);
      s.duty = (pick == 0) ? 22'd0 : (pick == 1) ? 22'd1000000 :
               (pick == 2) ? 22'h3FFFFF : 22'($urandom_range(0, 1000000));
      program_profile(s);
      for (int k = 0; k < SHORT_TICKS; k++)
        offer_tick(k == 0 || $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 6,
                   1'b0, QUIET);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d ticks under %0d register settings, %0d runs ended, %0d of them preempted",
             ticks_sent, settings_loaded, runs_done, runs_cut);
    $display("%0d result words checked, %0d field mismatches", words_seen, fail_count);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== stepper_pump_ramp_profiler_top.f =====
src/spr_pkg.sv
src/stepper_pump_ramp_profiler_top.sv
bench/tb_stepper_pump_ramp_profiler_top.sv
